// ===== rtl/dlmb_pkg.sv =====
// Package for the depth linearisation / mask / bounding-box block.
// Holds widths, register indexes and the item structs shared by the RTL and testbench.
// No dependencies.
`default_nettype none
package dlmb_pkg;
  localparam int DepthBits = 24;
  localparam int CoordW    = 12;
  localparam int SideW     = 13;
  localparam int PlaneW    = 16;
  localparam int MaxSide   = 4096;
  // numerator n*f*2^24 < 2^56, denominator < 2^41
  localparam int NumW      = 2 * PlaneW + DepthBits;
  localparam int DenW      = PlaneW + DepthBits + 1;
  localparam int QCntW     = 6;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_NEAR   = 2'd2,
    REG_FAR    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIV_IDLE = 2'd0,
    DIV_RUN  = 2'd1,
    DIV_DONE = 2'd2
  } div_state_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic [NumW-1:0]   num;
    logic [DenW-1:0]   den;
    logic              bg;
    logic              frame_end;
    logic              box_valid;
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
  } job_t;

  typedef struct packed {
    logic [15:0]       depth_mm;
    logic              in_mask;
    logic              frame_done;
    logic              box_valid;
    logic [CoordW-1:0] box_left;
    logic [CoordW-1:0] box_top;
    logic [CoordW-1:0] box_right;
    logic [CoordW-1:0] box_bottom;
  } result_t;
endpackage
`default_nettype wire

// ===== rtl/dlmb_if.sv =====
// Handshake channel interfaces: pixel input, result output, register write.
// No dependencies.
`default_nettype none
interface dlmb_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] depth_code;
  modport source (output valid, output depth_code, input ready);
  modport sink   (input valid, input depth_code, output ready);
endinterface

interface dlmb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] depth_mm;
  logic        in_mask;
  logic        frame_done;
  logic        box_valid;
  logic [11:0] box_left;
  logic [11:0] box_top;
  logic [11:0] box_right;
  logic [11:0] box_bottom;
  modport source (output valid, output depth_mm, output in_mask, output frame_done,
                  output box_valid, output box_left, output box_top, output box_right,
                  output box_bottom, input ready);
  modport sink   (input valid, input depth_mm, input in_mask, input frame_done,
                  input box_valid, input box_left, input box_top, input box_right,
                  input box_bottom, output ready);
endinterface

interface dlmb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/dlmb_front.sv =====
// Front end: raster position, background test, bounding box, job build.
// Depends on dlmb_pkg.
`default_nettype none
module dlmb_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [23:0]                 in_code,
  input  wire logic [dlmb_pkg::SideW-1:0]  w_raw,
  input  wire logic [dlmb_pkg::SideW-1:0]  h_raw,
  input  wire logic [15:0]                 near_mm,
  input  wire logic [15:0]                 far_mm,
  output logic                             job_valid,
  input  wire logic                        job_ready,
  output dlmb_pkg::job_t                   job
);
  localparam int CW = dlmb_pkg::CoordW;
  localparam int DW = dlmb_pkg::DenW;

  logic [CW-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [CW-1:0] lc_r, lc_nxt, gc_r, gc_nxt, lr_r, lr_nxt, gr_r, gr_nxt;
  logic          any_r, any_nxt;
  logic [dlmb_pkg::SideW-1:0] w, h;
  logic [DW-1:0] fone, den, prod;
  logic [DW+7:0] lhs, rhs;
  logic          bg, row_end, frame_end, acc;
  logic [CW-1:0] lc_u, gc_u, lr_u, gr_u;
  logic [CW:0]   l, t, rr, b;
  logic [16:0]   diff;

  function automatic logic [dlmb_pkg::SideW-1:0] clamp_side(
    input logic [dlmb_pkg::SideW-1:0] v);
    if (v == '0) return dlmb_pkg::SideW'(1);
    if (v > dlmb_pkg::SideW'(dlmb_pkg::MaxSide)) return dlmb_pkg::SideW'(dlmb_pkg::MaxSide);
    return v;
  endfunction

  assign in_ready = job_ready;
  assign job_valid = in_valid;
  assign acc = in_valid && job_ready;

  always_comb begin
    w = clamp_side(w_raw);
    h = clamp_side(h_raw);
    fone = DW'({far_mm, 24'd0});
    if (far_mm >= near_mm) begin
      diff = 17'(far_mm - near_mm);
      prod = {17'd0, in_code} * {24'd0, diff};
      den  = fone - prod;
    end else begin
      diff = 17'(near_mm - far_mm);
      prod = {17'd0, in_code} * {24'd0, diff};
      den  = fone + prod;
    end
    lhs = (DW+8)'({near_mm, 24'd0}) * (DW+8)'(100);
    rhs = (DW+8)'(den) * (DW+8)'(99);
    bg  = (den != '0) && (far_mm != '0) && (lhs > rhs);
    row_end   = ({1'b0, col_r} + 13'd1) >= w;
    frame_end = row_end && (({1'b0, row_r} + 13'd1) >= h);
    lc_u = (!bg && col_r < lc_r) ? col_r : lc_r;
    gc_u = (!bg && col_r > gc_r) ? col_r : gc_r;
    lr_u = (!bg && row_r < lr_r) ? row_r : lr_r;
    gr_u = (!bg && row_r > gr_r) ? row_r : gr_r;
    l  = (lc_u > 0) ? {1'b0, lc_u} - 13'd1 : '0;
    t  = (lr_u > 0) ? {1'b0, lr_u} - 13'd1 : '0;
    rr = {1'b0, gc_u} + 13'd1;
    b  = {1'b0, gr_u} + 13'd1;
    if (l  > w - 13'd1) l  = w - 13'd1;
    if (t  > h - 13'd1) t  = h - 13'd1;
    if (rr > w - 13'd1) rr = w - 13'd1;
    if (b  > h - 13'd1) b  = h - 13'd1;

    job.num = {32'(near_mm) * 32'(far_mm), 24'd0};
    job.den = den;
    job.bg  = bg;
    job.frame_end = frame_end;
    job.box_valid = frame_end && (any_r || !bg);
    job.left   = job.box_valid ? l[CW-1:0]  : '0;
    job.top    = job.box_valid ? t[CW-1:0]  : '0;
    job.right  = job.box_valid ? rr[CW-1:0] : '0;
    job.bottom = job.box_valid ? b[CW-1:0]  : '0;

    col_nxt = col_r; row_nxt = row_r;
    lc_nxt = lc_u; gc_nxt = gc_u; lr_nxt = lr_u; gr_nxt = gr_u;
    any_nxt = any_r || !bg;
    if (frame_end) begin
      col_nxt = '0; row_nxt = '0;
      lc_nxt = '1; gc_nxt = '0; lr_nxt = '1; gr_nxt = '0; any_nxt = 1'b0;
    end else if (row_end) begin
      col_nxt = '0; row_nxt = row_r + 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0; row_r <= '0; lc_r <= '1; gc_r <= '0;
      lr_r <= '1; gr_r <= '0; any_r <= 1'b0;
    end else if (acc) begin
      col_r <= col_nxt; row_r <= row_nxt; lc_r <= lc_nxt; gc_r <= gc_nxt;
      lr_r <= lr_nxt; gr_r <= gr_nxt; any_r <= any_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/dlmb_fifo.sv =====
// Two-entry queue between the front end and the divider back end.
// Depends on dlmb_pkg.
`default_nettype none
module dlmb_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire dlmb_pkg::job_t wr_data,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output dlmb_pkg::job_t      rd_data
);
  dlmb_pkg::job_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/dlmb_back.sv =====
// Back end: restoring divider one quotient bit per cycle, rounding, result register.
// Depends on dlmb_pkg.
`default_nettype none
module dlmb_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           job_valid,
  output logic                job_ready,
  input  wire dlmb_pkg::job_t job,
  output logic                res_valid,
  input  wire logic           res_ready,
  output dlmb_pkg::result_t   res
);
  localparam int NW = dlmb_pkg::NumW;
  localparam int DW = dlmb_pkg::DenW;

  dlmb_pkg::div_state_t st_r, st_nxt;
  dlmb_pkg::job_t       job_r;
  logic [NW-1:0]        q_r, q_nxt;
  logic [DW:0]          rem_r, rem_nxt;
  logic [dlmb_pkg::QCntW-1:0] cnt_r, cnt_nxt;
  logic [DW+1:0]        trial;
  logic [DW+1:0]        r2;
  logic                 up;
  logic [NW-1:0]        qr;
  logic [15:0]          z;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      dlmb_pkg::DIV_IDLE: if (job_valid) st_nxt = dlmb_pkg::DIV_RUN;
      dlmb_pkg::DIV_RUN:  if (cnt_r == '0) st_nxt = dlmb_pkg::DIV_DONE;
      dlmb_pkg::DIV_DONE: if (res_ready) st_nxt = dlmb_pkg::DIV_IDLE;
      default:            st_nxt = dlmb_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (st_r == dlmb_pkg::DIV_IDLE);
    res_valid = (st_r == dlmb_pkg::DIV_DONE);
    trial = {rem_r, job_r.num[cnt_r]} - {1'b0, job_r.den};
    if (!trial[DW+1]) begin
      rem_nxt = trial[DW:0];
      q_nxt   = {q_r[NW-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[DW-1:0], job_r.num[cnt_r]};
      q_nxt   = {q_r[NW-2:0], 1'b0};
    end
    cnt_nxt = cnt_r - 1'b1;
    r2 = {rem_r, 1'b0};
    up = (r2 > {1'b0, job_r.den}) || ((r2 == {1'b0, job_r.den}) && q_r[0]);
    qr = q_r + NW'(up);
    if (job_r.den == '0 || job_r.bg) z = '0;
    else if (qr > NW'(16'hFFFF)) z = 16'hFFFF;
    else z = qr[15:0];
    res.depth_mm   = z;
    res.in_mask    = !job_r.bg;
    res.frame_done = job_r.frame_end;
    res.box_valid  = job_r.box_valid;
    res.box_left   = job_r.left;
    res.box_top    = job_r.top;
    res.box_right  = job_r.right;
    res.box_bottom = job_r.bottom;
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) job_r <= job;
    if (st_r == dlmb_pkg::DIV_IDLE) begin
      q_r <= '0; rem_r <= '0; cnt_r <= dlmb_pkg::QCntW'(NW - 1);
    end else if (st_r == dlmb_pkg::DIV_RUN) begin
      q_r <= q_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= dlmb_pkg::DIV_IDLE;
    else        st_r <= st_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/depth_linearize_mask_bbox.sv =====
// Top level: register file, front end, queue and divider back end.
// Depends on dlmb_pkg, dlmb_if, dlmb_front, dlmb_fifo, dlmb_back.
//
// Channel | Dir | Payload
// in_     | in  | depth_code[23:0]
// out_    | out | depth_mm, in_mask, frame_done, box_valid, box edges
// cfg_    | in  | index[1:0], data[15:0]
//
// The one-bit-per-cycle divider handles one pixel at a time: a load state, the
// quotient steps and a result state held while the output stalls. The front end
// classifies and tracks the box in its accept cycle; a two-deep queue decouples
// it from the divider.
// Synchronous active-low reset; registers return to 640x480, 100..10000 mm.
// Output stalls hold the divider result; the front stalls only when the queue fills.
`default_nettype none
module depth_linearize_mask_bbox (
  input wire logic     clk,
  input wire logic     rst_n,
  dlmb_in_if.sink      in_ch,
  dlmb_out_if.source   out_ch,
  dlmb_cfg_if.sink     cfg_ch
);
  logic [dlmb_pkg::SideW-1:0] w_r, h_r;
  logic [15:0] near_r, far_r;
  logic fj_valid, fj_ready, bj_valid, bj_ready, r_valid;
  dlmb_pkg::job_t fj, bj;
  dlmb_pkg::result_t r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= dlmb_pkg::SideW'(640); h_r <= dlmb_pkg::SideW'(480);
      near_r <= 16'd100; far_r <= 16'd10000;
    end else if (cfg_ch.valid) begin
      unique case (dlmb_pkg::reg_idx_t'(cfg_ch.index))
        dlmb_pkg::REG_WIDTH:  w_r <= cfg_ch.data[dlmb_pkg::SideW-1:0];
        dlmb_pkg::REG_HEIGHT: h_r <= cfg_ch.data[dlmb_pkg::SideW-1:0];
        dlmb_pkg::REG_NEAR:   near_r <= cfg_ch.data;
        dlmb_pkg::REG_FAR:    far_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  dlmb_front u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_code(in_ch.depth_code), .w_raw(w_r), .h_raw(h_r), .near_mm(near_r),
    .far_mm(far_r), .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  dlmb_fifo u_fifo (
    .clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
  );

  dlmb_back u_back (
    .clk, .rst_n, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .res_valid(r_valid), .res_ready(out_ch.ready), .res(r)
  );

  assign out_ch.valid      = r_valid;
  assign out_ch.depth_mm   = r.depth_mm;
  assign out_ch.in_mask    = r.in_mask;
  assign out_ch.frame_done = r.frame_done;
  assign out_ch.box_valid  = r.box_valid;
  assign out_ch.box_left   = r.box_left;
  assign out_ch.box_top    = r.box_top;
  assign out_ch.box_right  = r.box_right;
  assign out_ch.box_bottom = r.box_bottom;
endmodule
`default_nettype wire

// ===== sim/tb_depth_linearize_mask_bbox.sv =====
// Testbench for depth_linearize_mask_bbox: directed table then randomised frames,
// with a built-in depth/mask/box predictor and stalls on both channels.
// Depends on dlmb_pkg, dlmb_if and the RTL top level.
`default_nettype none
module tb_depth_linearize_mask_bbox;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned CodeOne = 64'd1 << dlmb_pkg::DepthBits;

  typedef struct {
    bit [23:0] code;
    bit        typed;   // expectation typed in below rather than predicted
    bit [15:0] depth;
    bit        mask;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst_n;

  dlmb_in_if  in_ch ();
  dlmb_out_if out_ch ();
  dlmb_cfg_if cfg_ch ();

  depth_linearize_mask_bbox DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of registers and frame state
  int unsigned width_r = 640, height_r = 480, near_r = 100, far_r = 10000;
  int unsigned col_pos = 0, row_pos = 0, min_col = 'hFFF, max_col = 0;
  int unsigned min_row = 'hFFF, max_row = 0;
  bit          seen_fg = 1'b0;

  pixel_row_t          pixels_in_flight[$];
  dlmb_pkg::result_t   expected_results[$];
  int                  errors = 0;
  bit                  jitter = 1'b1;
  int                  stall_left = 0;

  function automatic int unsigned clamp_side(int unsigned v);
    if (v == 0) return 1;
    if (v > dlmb_pkg::MaxSide) return dlmb_pkg::MaxSide;
    return v;
  endfunction

  function automatic dlmb_pkg::result_t linearise_pixel(bit [23:0] code);
    longint unsigned   n, f, c, num, den, q, rem, z;
    bit                bg, row_end, fend;
    int unsigned       w, h, l, t, rr, b;
    dlmb_pkg::result_t e;
    n = near_r;
    f = far_r;
    c = code;
    num = n * f * CodeOne;
    den = (f >= n) ? f * CodeOne - c * (f - n) : f * CodeOne + c * (n - f);
    z = 0;
    bg = 1'b0;
    if (den != 0) begin
      q = num / den;
      rem = num % den;
      if (2 * rem > den || (2 * rem == den && q[0])) q++;
      z = (q > 65535) ? 65535 : q;
      // z > 0.99*far, multiplied out
      if (f != 0 && 100 * n * CodeOne > 99 * den) bg = 1'b1;
    end
    e = '0;
    if (bg) begin
      z = 0;
    end else begin
      seen_fg = 1'b1;
      if (col_pos < min_col) min_col = col_pos;
      if (col_pos > max_col) max_col = col_pos;
      if (row_pos < min_row) min_row = row_pos;
      if (row_pos > max_row) max_row = row_pos;
    end
    w = clamp_side(width_r);
    h = clamp_side(height_r);
    row_end = (col_pos + 1 >= w);
    fend = row_end && (row_pos + 1 >= h);
    e.depth_mm = z[15:0];
    e.in_mask = !bg;
    e.frame_done = fend;
    if (fend) begin
      if (seen_fg) begin
        l = (min_col > 0) ? min_col - 1 : 0;
        t = (min_row > 0) ? min_row - 1 : 0;
        rr = max_col + 1;
        b = max_row + 1;
        if (l > w - 1) l = w - 1;
        if (t > h - 1) t = h - 1;
        if (rr > w - 1) rr = w - 1;
        if (b > h - 1) b = h - 1;
        e.box_valid = 1'b1;
        e.box_left = l[11:0];
        e.box_top = t[11:0];
        e.box_right = rr[11:0];
        e.box_bottom = b[11:0];
      end
      col_pos = 0; row_pos = 0; min_col = 'hFFF; max_col = 0;
      min_row = 'hFFF; max_row = 0; seen_fg = 1'b0;
    end else if (row_end) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return e;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // input transfers feed the predictor
  always @(posedge clk) begin
    pixel_row_t        r;
    dlmb_pkg::result_t e;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      r = pixels_in_flight.pop_front();
      e = linearise_pixel(in_ch.depth_code);
      if (r.typed) begin
        e.depth_mm = r.depth;
        e.in_mask = r.mask;
      end
      expected_results.push_back(e);
    end
  end

  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      case (dlmb_pkg::reg_idx_t'(cfg_ch.index))
        dlmb_pkg::REG_WIDTH:  width_r = cfg_ch.data & 16'h1FFF;
        dlmb_pkg::REG_HEIGHT: height_r = cfg_ch.data & 16'h1FFF;
        dlmb_pkg::REG_NEAR:   near_r = cfg_ch.data;
        dlmb_pkg::REG_FAR:    far_r = cfg_ch.data;
        default: ;
      endcase
    end
  end

  // result side: random back-pressure and checking
  always @(posedge clk) begin
    dlmb_pkg::result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        e = expected_results.pop_front();
        if (out_ch.depth_mm !== e.depth_mm) report("depth_mm", out_ch.depth_mm, e.depth_mm);
        if (out_ch.in_mask !== e.in_mask) report("in_mask", out_ch.in_mask, e.in_mask);
        if (out_ch.frame_done !== e.frame_done)
          report("frame_done", out_ch.frame_done, e.frame_done);
        if (out_ch.box_valid !== e.box_valid)
          report("box_valid", out_ch.box_valid, e.box_valid);
        if (out_ch.box_left !== e.box_left) report("box_left", out_ch.box_left, e.box_left);
        if (out_ch.box_top !== e.box_top) report("box_top", out_ch.box_top, e.box_top);
        if (out_ch.box_right !== e.box_right)
          report("box_right", out_ch.box_right, e.box_right);
        if (out_ch.box_bottom !== e.box_bottom)
          report("box_bottom", out_ch.box_bottom, e.box_bottom);
      end
    end
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (jitter && $urandom_range(0, 99) < 12)
        stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                 : $urandom_range(20, 150);
    end
  end

  function automatic int pick_gap();
    if (!jitter || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  task automatic send_pixel(pixel_row_t r);
    int gap;
    gap = pick_gap();
    pixels_in_flight.push_back(r);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.depth_code <= r.code;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // valid is left high so that writes can follow back to back
  task automatic write_reg(dlmb_pkg::reg_idx_t idx, bit [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // wait for every result, then let the divider settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pixels_in_flight.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic bit [23:0] pick_code(int bias);
    case ($urandom_range(0, 3) + bias)
      0:       return 24'($urandom);
      1:       return 24'($urandom_range(0, 255));
      default: return 24'(24'hFFFFFF - $urandom_range(0, 1 << ($urandom_range(0, 20))));
    endcase
  endfunction

  function automatic bit [15:0] pick_side();
    case ($urandom_range(0, 15))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd4096;
      default: return 16'($urandom_range(1, 7));
    endcase
  endfunction

  function automatic bit [15:0] pick_plane();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(50, 20000));
    endcase
  endfunction

  pixel_row_t directed[] = '{
    '{24'h000000, 1'b1, 16'd100, 1'b1},  // code 0 gives near plane
    '{24'hFFFFFF, 1'b1, 16'd0, 1'b0},    // full code lies beyond 0.99*far
    '{24'h000001, 1'b0, 16'd0, 1'b0},
    '{24'hFFFFFE, 1'b0, 16'd0, 1'b0},
    '{24'h800000, 1'b0, 16'd0, 1'b0},
    '{24'hFF0000, 1'b0, 16'd0, 1'b0},
    '{24'hFFF000, 1'b0, 16'd0, 1'b0},
    '{24'hAAAAAA, 1'b0, 16'd0, 1'b0},
    '{24'h555555, 1'b0, 16'd0, 1'b0},
    '{24'hFD70A4, 1'b0, 16'd0, 1'b0}
  };

  // w, h, near, far: empty planes, oversize frame, near past far, widest range
  bit [15:0] edge_cfg[4][4] = '{
    '{16'd0, 16'd0, 16'd0, 16'd0},
    '{16'hFFFF, 16'd2, 16'hFFFF, 16'hFFFF},
    '{16'd3, 16'd2, 16'hFFFF, 16'd1},
    '{16'd2, 16'd2, 16'd1, 16'hFFFF}
  };

  initial begin
    pixel_row_t r;
    int         bias;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.depth_code <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= dlmb_pkg::REG_WIDTH;
    cfg_ch.data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_pixel(directed[i]);
    drain();

    for (int p = 0; p < 16; p++) begin
      jitter = (p % 5 != 3);
      if (p < 4) begin
        write_reg(dlmb_pkg::REG_WIDTH, edge_cfg[p][0]);
        write_reg(dlmb_pkg::REG_HEIGHT, edge_cfg[p][1]);
        write_reg(dlmb_pkg::REG_NEAR, edge_cfg[p][2]);
        write_reg(dlmb_pkg::REG_FAR, edge_cfg[p][3]);
      end else begin
        write_reg(dlmb_pkg::REG_WIDTH, pick_side());
        write_reg(dlmb_pkg::REG_HEIGHT, pick_side());
        write_reg(dlmb_pkg::REG_NEAR, pick_plane());
        write_reg(dlmb_pkg::REG_FAR, pick_plane());
      end
      cfg_ch.valid <= 1'b0;
      bias = $urandom_range(0, 1);
      for (int k = 0; k < 46; k++) begin
        r = '{pick_code(bias), 1'b0, 16'd0, 1'b0};
        send_pixel(r);
      end
      drain();
    end

    if (errors == 0)
      $display("tb_depth_linearize_mask_bbox OK");
    else
      $display("tb_depth_linearize_mask_bbox NOT OK");
    $finish;
  end

  initial begin
    #40ms;
    $display("tb_depth_linearize_mask_bbox NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/dlmb_pkg.sv
rtl/dlmb_if.sv
rtl/dlmb_front.sv
rtl/dlmb_fifo.sv
rtl/dlmb_back.sv
rtl/depth_linearize_mask_bbox.sv
sim/tb_depth_linearize_mask_bbox.sv
